>>> hdl/sdes_pkg.sv
// Shared types and constants of the servo drive enable stepper.
package sdes_pkg;

    localparam int unsigned IDX_W    = 4;
    localparam int unsigned NUM_IDX  = 16;
    localparam int unsigned SW_W     = 16;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned MODE_W   = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned HOLD_W   = 7;
    localparam int unsigned PLAN_W   = 31;
    localparam int unsigned CFGV_W   = 30;
    localparam int unsigned CFGA_W   = 2;

    // Configuration register indexes.
    localparam logic [CFGA_W-1:0] REG_POSITION_STEP  = 2'd0;
    localparam logic [CFGA_W-1:0] REG_POSITION_LIMIT = 2'd1;
    localparam logic [CFGA_W-1:0] REG_HOLD_CYCLES    = 2'd2;

    localparam logic [CFGV_W-1:0] RST_POSITION_STEP  = 30'd1000000;
    localparam logic [CFGV_W-1:0] RST_POSITION_LIMIT = 30'd10000000;
    localparam logic [HOLD_W-1:0] RST_HOLD_CYCLES    = 7'd10;

    // Status word bits and states.
    localparam logic [SW_W-1:0] SW_FAULT        = 16'h0008;
    localparam logic [SW_W-1:0] SW_STATE_MASK   = 16'h006F;
    localparam logic [SW_W-1:0] SW_READY        = 16'h0021;
    localparam logic [SW_W-1:0] SW_SWITCHED_ON  = 16'h0023;
    localparam logic [SW_W-1:0] SW_OP_ENABLED   = 16'h0027;
    localparam logic [SW_W-1:0] SW_TARGET_REACH = 16'h0400;

    // Control word commands.
    localparam logic [SW_W-1:0] CW_FAULT_RESET  = 16'h0080;
    localparam logic [SW_W-1:0] CW_SHUTDOWN     = 16'h0006;
    localparam logic [SW_W-1:0] CW_SWITCH_ON    = 16'h0007;
    localparam logic [SW_W-1:0] CW_ENABLE_OP    = 16'h000F;
    localparam logic [SW_W-1:0] CW_NEW_SETPOINT = 16'h001F;

    localparam logic [MODE_W-1:0] MODE_PROFILE_POS = 8'h01;

    // Per-drive phase codes; the unused codes behave as start.
    localparam logic [PHASE_W-1:0] PH_START    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SHUTDOWN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SWITCH   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ENABLE   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MOVING   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ADVANCE  = 3'd5;

    typedef struct packed {
        logic [PHASE_W-1:0]     phase;
        logic [HOLD_W-1:0]      hold;
        logic [PLAN_W-1:0]      planned;
        logic signed [POS_W-1:0] sent_target;
        logic [MODE_W-1:0]      sent_mode;
    } t_entry;

    typedef struct packed {
        logic [CFGV_W-1:0] step;
        logic [CFGV_W-1:0] limit;
        logic [HOLD_W-1:0] hold;
    } t_cfg;

endpackage

>>> hdl/sdes_if.sv
// Handshake channel interfaces for items, results and configuration writes.
interface sdes_in_if;
    logic                   valid;
    logic                   ready;
    logic [3:0]             drive_index;
    logic [15:0]            status_word;
    logic signed [31:0]     current_position;

    modport source (output valid, drive_index, status_word, current_position, input ready);
    modport sink   (input valid, drive_index, status_word, current_position, output ready);
endinterface

interface sdes_out_if;
    logic                   valid;
    logic                   ready;
    logic [15:0]            control_word;
    logic signed [31:0]     target_position;
    logic [7:0]             target_mode;

    modport source (output valid, control_word, target_position, target_mode, input ready);
    modport sink   (input valid, control_word, target_position, target_mode, output ready);
endinterface

interface sdes_cfg_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             index;
    logic [29:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sdes_step.sv
// Next-state and command logic for one drive entry and one status word.
module sdes_step (
    input  sdes_pkg::t_entry              i_entry,
    input  sdes_pkg::t_cfg                i_cfg,
    input  logic [sdes_pkg::SW_W-1:0]     i_status_word,
    input  logic signed [sdes_pkg::POS_W-1:0] i_current_position,
    output sdes_pkg::t_entry              o_entry,
    output logic [sdes_pkg::SW_W-1:0]     o_control_word
);
    import sdes_pkg::*;

    logic [SW_W-1:0]   w_st;
    logic [PLAN_W-1:0] w_sum;
    logic [PLAN_W-1:0] w_next_plan;

    assign w_st  = i_status_word & SW_STATE_MASK;
    // The planned target wraps at 31 bits before the limit compare.
    assign w_sum = i_entry.planned + PLAN_W'(i_cfg.step);
    assign w_next_plan = (w_sum > PLAN_W'(i_cfg.limit)) ? '0 : w_sum;

    always_comb begin
        o_entry        = i_entry;
        o_control_word = CW_FAULT_RESET;
        if ((i_status_word & SW_FAULT) != '0) begin
            o_entry.sent_mode = MODE_PROFILE_POS;
        end else begin
            case (i_entry.phase)
                PH_SHUTDOWN: begin
                    if (w_st == SW_READY) o_entry.phase = PH_SWITCH;
                    o_control_word      = CW_SHUTDOWN;
                    o_entry.sent_target = i_current_position;
                end
                PH_SWITCH: begin
                    if (w_st == SW_SWITCHED_ON) o_entry.phase = PH_ENABLE;
                    o_control_word = CW_SWITCH_ON;
                end
                PH_ENABLE: begin
                    if (w_st == SW_OP_ENABLED) o_entry.phase = PH_MOVING;
                    o_control_word = CW_ENABLE_OP;
                end
                PH_MOVING: begin
                    if (w_st != SW_OP_ENABLED) o_entry.phase = PH_SHUTDOWN;
                    // Target reached is applied last, so with no hold left it overrides a failed check.
                    if ((i_status_word & SW_TARGET_REACH) != '0) begin
                        if (i_entry.hold != '0) o_entry.hold = i_entry.hold - HOLD_W'(1);
                        else                    o_entry.phase = PH_ADVANCE;
                    end
                    o_control_word      = CW_NEW_SETPOINT;
                    o_entry.sent_mode   = MODE_PROFILE_POS;
                    o_entry.sent_target = POS_W'(i_entry.planned);
                end
                PH_ADVANCE: begin
                    o_entry.planned     = w_next_plan;
                    o_entry.hold        = i_cfg.hold;
                    o_entry.phase       = PH_ENABLE;
                    o_control_word      = CW_ENABLE_OP;
                    o_entry.sent_mode   = MODE_PROFILE_POS;
                    o_entry.sent_target = POS_W'(w_next_plan);
                end
                default: begin
                    o_entry.phase     = PH_SHUTDOWN;
                    o_control_word    = CW_FAULT_RESET;
                    o_entry.sent_mode = MODE_PROFILE_POS;
                end
            endcase
        end
    end

endmodule

>>> hdl/servo_drive_enable_stepper.sv
// Top level of the servo drive enable stepper: per-drive state memory and handshakes.
//
//  Port      Direction  Carries
//  i_item    sink       drive_index, status_word, current_position
//  o_result  source     control_word, target_position, target_mode
//  i_cfg     sink       index (0 step, 1 limit, 2 hold cycles), data
//
// An item is read from the state memory in the cycle it is accepted and is
// updated and written back when the update stage fires, which also registers its
// result; a new item can be accepted every cycle unless a result stalls. A write
// and a read of the same drive on one edge are resolved by a forwarding register.
// Reset clears the per-drive valid bits at once; a drive never written reads as
// all zero. A stalled result holds the update stage, which in turn holds the input.
module servo_drive_enable_stepper #(
    parameter int unsigned MAX_DRIVES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdes_in_if.sink     i_item,
    sdes_out_if.source  o_result,
    sdes_cfg_if.sink    i_cfg
);
    import sdes_pkg::*;

    localparam int unsigned AW = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;

    t_cfg                r_cfg;
    t_entry              r_mem [MAX_DRIVES];
    logic [MAX_DRIVES-1:0] r_ent_vld;
    logic [AW-1:0]       w_addr_map [NUM_IDX];
    logic [AW-1:0]       w_in_addr;
    logic                w_in_fire;
    logic                w_s1_fire;

    logic                r_s1_valid;
    logic [AW-1:0]       r_s1_addr;
    logic [SW_W-1:0]     r_s1_sw;
    logic signed [POS_W-1:0] r_s1_pos;
    t_entry              r_rd_data;
    logic                r_rd_vld;
    logic                r_fwd_hit;
    t_entry              r_fwd_data;
    t_entry              w_cur;
    t_entry              w_new;
    logic [SW_W-1:0]     w_cw;

    logic                r_out_valid;

    // Drive index reduced modulo the drive count, as a constant table.
    for (genvar g = 0; g < NUM_IDX; g++) begin : g_map
        assign w_addr_map[g] = AW'(g % MAX_DRIVES);
    end
    assign w_in_addr = w_addr_map[i_item.drive_index];

    assign i_cfg.ready  = 1'b1;
    assign w_s1_fire    = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_s1_fire;
    assign w_in_fire    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step  <= RST_POSITION_STEP;
            r_cfg.limit <= RST_POSITION_LIMIT;
            r_cfg.hold  <= RST_HOLD_CYCLES;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POSITION_STEP:  r_cfg.step  <= i_cfg.data;
                REG_POSITION_LIMIT: r_cfg.limit <= i_cfg.data;
                REG_HOLD_CYCLES:    r_cfg.hold  <= i_cfg.data[HOLD_W-1:0];
                default:            ;
            endcase
        end
    end

    // State memory: one write port from the update stage, one read port at accept.
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) r_mem[r_s1_addr] <= w_new;
        if (w_in_fire) r_rd_data <= r_mem[w_in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (w_s1_fire) r_ent_vld[r_s1_addr] <= 1'b1;
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
                r_rd_vld   <= r_ent_vld[w_in_addr];
                // The memory returns the old entry when the same drive is written now.
                r_fwd_hit  <= w_s1_fire && (r_s1_addr == w_in_addr);
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_addr  <= w_in_addr;
            r_s1_sw    <= i_item.status_word;
            r_s1_pos   <= i_item.current_position;
            r_fwd_data <= w_new;
        end
    end

    always_comb begin
        if (r_fwd_hit)     w_cur = r_fwd_data;
        else if (r_rd_vld) w_cur = r_rd_data;
        else               w_cur = '0;
    end

    sdes_step u_step (
        .i_entry            (w_cur),
        .i_cfg              (r_cfg),
        .i_status_word      (r_s1_sw),
        .i_current_position (r_s1_pos),
        .o_entry            (w_new),
        .o_control_word     (w_cw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            o_result.control_word    <= w_cw;
            o_result.target_position <= w_new.sent_target;
            o_result.target_mode     <= w_new.sent_mode;
        end
    end

    assign o_result.valid = r_out_valid;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the servo drive enable stepper: directed table, then random traffic.
module tb_top;
    import sdes_pkg::*;

    localparam int unsigned LONG_STALL_CYCLES = 60;
    localparam int unsigned WATCHDOG_LIMIT    = 1000;
    localparam int unsigned NUM_DIRECTED      = 19;

    // Status bits that neither the state decode nor target-reached looks at.
    localparam logic [SW_W-1:0] SW_SPARE_BITS = ~(SW_STATE_MASK | SW_TARGET_REACH);

    typedef struct packed {
        logic [SW_W-1:0]         cw;
        logic signed [POS_W-1:0] target;
        logic [MODE_W-1:0]       mode;
    } t_drive_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] d;
        logic [SW_W-1:0]  sw;
        logic [POS_W-1:0] pos;
        logic             typed;
        t_drive_cmd       cmd;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{4'd0,  16'h0000, 32'h0, 1'b1, '{CW_FAULT_RESET, 32'h0, MODE_PROFILE_POS}},
        '{4'd0,  16'hFFFF, 32'hFFFFFFFF, 1'b1, '{CW_FAULT_RESET, 32'h0, MODE_PROFILE_POS}},
        '{4'd0,  SW_READY, 32'h7FFFFFFF, 1'b1, '{CW_SHUTDOWN, 32'h7FFFFFFF, MODE_PROFILE_POS}},
        '{4'd0,  SW_SWITCHED_ON, 32'h0, 1'b1, '{CW_SWITCH_ON, 32'h7FFFFFFF, MODE_PROFILE_POS}},
        '{4'd0,  SW_OP_ENABLED, 32'h0, 1'b1, '{CW_ENABLE_OP, 32'h7FFFFFFF, MODE_PROFILE_POS}},
        '{4'd0,  SW_OP_ENABLED | SW_TARGET_REACH, 32'h0, 1'b1,
                 '{CW_NEW_SETPOINT, 32'h0, MODE_PROFILE_POS}},
        '{4'd0,  16'h0000, 32'h0, 1'b1, '{CW_ENABLE_OP, 32'd1000000, MODE_PROFILE_POS}},
        '{4'd0,  SW_OP_ENABLED, 32'h0, 1'b0, '0},
        '{4'd0,  SW_OP_ENABLED | SW_TARGET_REACH, 32'h0, 1'b0, '0},
        '{4'd0,  SW_TARGET_REACH, 32'h0, 1'b0, '0},
        '{4'd0,  SW_SPARE_BITS, 32'h12345678, 1'b0, '0},
        '{4'd15, ~SW_FAULT, 32'h0, 1'b1, '{CW_FAULT_RESET, 32'h0, MODE_PROFILE_POS}},
        '{4'd15, SW_READY, 32'h80000000, 1'b1, '{CW_SHUTDOWN, 32'h80000000, MODE_PROFILE_POS}},
        '{4'd15, SW_SWITCHED_ON, 32'h0, 1'b0, '0},
        '{4'd15, SW_OP_ENABLED, 32'h0, 1'b0, '0},
        // Enabled check fails with target reached and no hold left: advance must win.
        '{4'd15, SW_TARGET_REACH, 32'h0, 1'b1, '{CW_NEW_SETPOINT, 32'h0, MODE_PROFILE_POS}},
        '{4'd15, 16'h0000, 32'h0, 1'b1, '{CW_ENABLE_OP, 32'd1000000, MODE_PROFILE_POS}},
        '{4'd15, SW_FAULT, 32'h0, 1'b1, '{CW_FAULT_RESET, 32'd1000000, MODE_PROFILE_POS}},
        '{4'd7,  SW_FAULT, 32'h0, 1'b1, '{CW_FAULT_RESET, 32'h0, MODE_PROFILE_POS}}
    };

    logic i_clk;
    logic i_rst_n;

    sdes_in_if  item_ch ();
    sdes_out_if result_ch ();
    sdes_cfg_if cfg_ch ();

    servo_drive_enable_stepper #(
        .MAX_DRIVES(NUM_IDX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted per-drive state and register copy.
    logic [PHASE_W-1:0]      phase_mem  [NUM_IDX] = '{default: '0};
    logic [HOLD_W-1:0]       hold_mem   [NUM_IDX] = '{default: '0};
    logic [PLAN_W-1:0]       plan_mem   [NUM_IDX] = '{default: '0};
    logic signed [POS_W-1:0] target_mem [NUM_IDX] = '{default: '0};
    logic [MODE_W-1:0]       mode_mem   [NUM_IDX] = '{default: '0};
    t_cfg cfg_model = '{RST_POSITION_STEP, RST_POSITION_LIMIT, RST_HOLD_CYCLES};

    t_drive_cmd  expected_cmds [$];
    t_drive_cmd  typed_cmd;
    bit          check_typed  = 1'b0;
    bit          idle_on      = 1'b1;
    bit          hold_results = 1'b0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_drive_cmd next_drive_command(input logic [IDX_W-1:0] d,
                                                      input logic [SW_W-1:0] sw,
                                                      input logic [POS_W-1:0] cur);
        t_drive_cmd        cmd;
        logic [SW_W-1:0]   st;
        logic [PLAN_W-1:0] adv;
        st = sw & SW_STATE_MASK;
        if ((sw & SW_FAULT) != '0) begin
            cmd.cw = CW_FAULT_RESET;
            mode_mem[d] = MODE_PROFILE_POS;
        end else begin
            case (phase_mem[d])
                PH_SHUTDOWN: begin
                    if (st == SW_READY) phase_mem[d] = PH_SWITCH;
                    cmd.cw = CW_SHUTDOWN;
                    target_mem[d] = cur;
                end
                PH_SWITCH: begin
                    if (st == SW_SWITCHED_ON) phase_mem[d] = PH_ENABLE;
                    cmd.cw = CW_SWITCH_ON;
                end
                PH_ENABLE: begin
                    if (st == SW_OP_ENABLED) phase_mem[d] = PH_MOVING;
                    cmd.cw = CW_ENABLE_OP;
                end
                PH_MOVING: begin
                    // Target-reached is looked at last, so with no hold left it overrides a lost enable.
                    if (st != SW_OP_ENABLED) phase_mem[d] = PH_SHUTDOWN;
                    if ((sw & SW_TARGET_REACH) != '0) begin
                        if (hold_mem[d] != '0) hold_mem[d] = hold_mem[d] - 1'b1;
                        else phase_mem[d] = PH_ADVANCE;
                    end
                    cmd.cw = CW_NEW_SETPOINT;
                    mode_mem[d] = MODE_PROFILE_POS;
                    target_mem[d] = {1'b0, plan_mem[d]};
                end
                PH_ADVANCE: begin
                    adv = plan_mem[d] + {1'b0, cfg_model.step};
                    if (adv > {1'b0, cfg_model.limit}) adv = '0;
                    plan_mem[d] = adv;
                    hold_mem[d] = cfg_model.hold;
                    phase_mem[d] = PH_ENABLE;
                    cmd.cw = CW_ENABLE_OP;
                    mode_mem[d] = MODE_PROFILE_POS;
                    target_mem[d] = {1'b0, adv};
                end
                default: begin
                    // Start, and the two unused codes that behave like it.
                    phase_mem[d] = PH_SHUTDOWN;
                    cmd.cw = CW_FAULT_RESET;
                    mode_mem[d] = MODE_PROFILE_POS;
                end
            endcase
        end
        cmd.target = target_mem[d];
        cmd.mode = mode_mem[d];
        return cmd;
    endfunction

    // Mostly the status word that moves the drive on, with random spare bits;
    // now and then a fault, a random word, or enable dropped while target is reached.
    function automatic logic [SW_W-1:0] pick_status(input logic [IDX_W-1:0] d);
        logic [SW_W-1:0] noise;
        int unsigned     roll;
        noise = SW_W'($urandom) & SW_SPARE_BITS;
        roll = $urandom_range(0, 99);
        if (roll < 3) return SW_W'($urandom) | SW_FAULT;
        if (roll < 7) return SW_W'($urandom) & ~SW_FAULT;
        case (phase_mem[d])
            PH_SHUTDOWN: return SW_READY | noise;
            PH_SWITCH:   return SW_SWITCHED_ON | noise;
            PH_ENABLE:   return SW_OP_ENABLED | noise;
            PH_MOVING: begin
                if (roll < 10) return SW_TARGET_REACH | noise;
                if (roll < 75) return SW_OP_ENABLED | SW_TARGET_REACH | noise;
                return SW_OP_ENABLED | noise;
            end
            default: return SW_W'($urandom) & ~SW_FAULT;
        endcase
    endfunction

    task automatic offer_item(input logic [IDX_W-1:0] d, input logic [SW_W-1:0] sw,
                              input logic [POS_W-1:0] pos, input logic typed,
                              input t_drive_cmd cmd);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        item_ch.valid = 1'b1;
        item_ch.drive_index = d;
        item_ch.status_word = sw;
        item_ch.current_position = pos;
        check_typed = typed;
        typed_cmd = cmd;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic settle_pipeline();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        check_typed = 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFGA_W-1:0] idx, input logic [CFGV_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Predictions are made and results checked in one place, so that an item
    // and a result on the same edge are always handled in the same order.
    always @(posedge i_clk) begin
        t_drive_cmd predicted;
        t_drive_cmd want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_POSITION_STEP:  cfg_model.step = cfg_ch.data;
                    REG_POSITION_LIMIT: cfg_model.limit = cfg_ch.data;
                    REG_HOLD_CYCLES:    cfg_model.hold = cfg_ch.data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                predicted = next_drive_command(item_ch.drive_index, item_ch.status_word,
                                               item_ch.current_position);
                expected_cmds.push_back(check_typed ? typed_cmd : predicted);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: cw %h target %h mode %h",
                                 result_ch.control_word, result_ch.target_position,
                                 result_ch.target_mode);
                end else begin
                    want = expected_cmds.pop_front();
                    if (result_ch.control_word !== want.cw ||
                        result_ch.target_position !== want.target ||
                        result_ch.target_mode !== want.mode) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected cw %h target %h mode %h,",
                                      " got cw %h target %h mode %h"},
                                     want.cw, want.target, want.mode, result_ch.control_word,
                                     result_ch.target_position, result_ch.target_mode);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : result_pacing
        int unsigned gap;
        result_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                result_ch.ready = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge i_clk);
                result_ch.ready = 1'b1;
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                result_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
                result_ch.ready = 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [IDX_W-1:0]  d;
        logic [CFGV_W-1:0] step_v;
        logic [CFGV_W-1:0] limit_v;
        logic [HOLD_W-1:0] hold_v;
        int                count;
        item_ch.valid = 1'b0;
        item_ch.drive_index = '0;
        item_ch.status_word = '0;
        item_ch.current_position = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_POSITION_STEP;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i])
            offer_item(DIRECTED_ROWS[i].d, DIRECTED_ROWS[i].sw, DIRECTED_ROWS[i].pos,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].cmd);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin
                    step_v = '1; limit_v = '1; hold_v = '0; count = 300;
                end
                2: begin
                    // Limit dropped under the planned targets left by the last setting.
                    step_v = '0; limit_v = '0; hold_v = '1; count = 200;
                end
                3: begin
                    step_v = CFGV_W'($urandom_range(1, 3000000));
                    limit_v = CFGV_W'($urandom_range(0, 20000000));
                    hold_v = HOLD_W'($urandom_range(1, 6));
                    count = 400;
                end
                4: begin
                    step_v = CFGV_W'(1000000); limit_v = CFGV_W'(2500000); hold_v = 7'd2;
                    count = 350;
                end
                default: begin
                    step_v = RST_POSITION_STEP; limit_v = RST_POSITION_LIMIT;
                    hold_v = RST_HOLD_CYCLES;
                    count = (ph == 0) ? 300 : 380;
                end
            endcase
            if (ph != 0) begin
                settle_pipeline();
                write_register(REG_POSITION_STEP, step_v);
                write_register(REG_POSITION_LIMIT, limit_v);
                write_register(REG_HOLD_CYCLES, CFGV_W'(hold_v));
            end
            idle_on = (ph != 5);
            for (int n = 0; n < count; n++) begin
                d = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 3))
                                               : IDX_W'($urandom_range(0, 15));
                if ((ph == 1 || ph == 3) && n == count / 3) hold_results = 1'b1;
                offer_item(d, pick_status(d), POS_W'($urandom), 1'b0, '0);
            end
        end

        settle_pipeline();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
